FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL, included by the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define BDQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bdq assertion failed");

// Checked on every rising edge, reset included.
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bdq assertion failed");

`endif

FILE: rtl/core/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int TALLY_W  = 7;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_LENGTH     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] data_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped_value;
    logic [TALLY_W-1:0]       tally;
  } out_word_t;

  // control from the sequencer to the match unit
  typedef struct packed {
    logic load;  // capture key, clear count
    logic en;    // compare read data this cycle
  } match_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/bdq_ram.sv
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/bdq_match.sv
`default_nettype none

// Shared compare-and-count unit: one stored word per cycle against the key.
module bdq_match #(
  parameter int CNT_W = 7
) (
  input  wire logic                          clk,
  input  wire bdq_pkg::match_ctrl_t          ctrl,
  input  wire logic [bdq_pkg::DATA_W-1:0]    key,
  input  wire logic [bdq_pkg::DATA_W-1:0]    rd_data,
  output logic      [CNT_W-1:0]              count
);

  import bdq_pkg::*;

  logic [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= key;
      cnt_r <= '0;
    end else if (ctrl.en && (rd_data == key_r)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign count = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/core/bounded_deque_with_match_count_core.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit words, CAPACITY entries deep,
// with a length query and a match count. A word is taken when start is high
// and busy is low; each taken word gives exactly one result word on out_word,
// marked by a one-cycle out_strobe, and the receiver cannot stall it.
// Pushes, length queries, undefined actions and pops on an empty queue
// finish at once: the result shows in the cycle after acceptance and busy
// stays low, so one word per cycle is sustained. A pop that finds an entry
// holds busy while the registered entry memory read returns it. A search
// holds busy while the single read port feeds one stored entry per cycle
// into the shared compare unit, then posts the count. A push on a full
// queue is dropped with status full; a pop on an empty queue gives status
// empty and a zero value. The tally field keeps the low 7 bits of the count.
module bounded_deque_with_match_count_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bdq_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output bdq_pkg::out_word_t      out_word
);

  import bdq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = OCC_W + 1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // takes words, finishes short actions at once
    S_POPW = 4'b0010,  // pop: memory read data arrives
    S_SCAN = 4'b0100,  // search: walk entries front to back
    S_FIN  = 4'b1000   // search: last compare done, post count
  } state_t;

  // Store slot lying 'off' places after the front; sum stays below
  // 2*CAPACITY, so one compare and subtract wraps it.
  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                   input logic [OCC_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [IDX_W-1:0]  scan_ptr_r, scan_ptr_nxt;
  logic [OCC_W-1:0]  rem_r, rem_nxt;       // entries still to read
  logic              pend_r, pend_nxt;     // read data due for compare
  logic              out_strobe_r, out_strobe_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              accept;
  logic              is_full, is_empty;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;
  match_ctrl_t       mctrl;
  logic [OCC_W-1:0]  match_cnt;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign is_full  = (occ_r == OCC_W'(CAPACITY));
  assign is_empty = (occ_r == '0);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    scan_ptr_nxt   = scan_ptr_r;
    rem_nxt        = rem_r;
    pend_nxt       = 1'b0;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    wr_en          = 1'b0;
    wr_addr        = slot_after(front_r, occ_r);
    rd_en          = 1'b0;
    rd_addr        = scan_ptr_r;
    mctrl          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Default result: all zero, posted next cycle.
          out_word_nxt   = '0;
          out_strobe_nxt = 1'b1;
          case (in_word.action)
            ACT_PUSH_BACK: begin
              if (is_full) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = slot_after(front_r, occ_r);
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            ACT_PUSH_FRONT: begin
              if (is_full) begin
                out_word_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot_dec(front_r);
                front_nxt = slot_dec(front_r);
                occ_nxt   = occ_r + OCC_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (is_empty) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                // tail entry sits at front + occ - 1
                rd_en          = 1'b1;
                rd_addr        = slot_after(front_r, occ_r - OCC_W'(1));
                occ_nxt        = occ_r - OCC_W'(1);
                out_strobe_nxt = 1'b0;
                state_nxt      = S_POPW;
              end
            end
            ACT_POP_FRONT: begin
              if (is_empty) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                rd_en          = 1'b1;
                rd_addr        = front_r;
                front_nxt      = slot_inc(front_r);
                occ_nxt        = occ_r - OCC_W'(1);
                out_strobe_nxt = 1'b0;
                state_nxt      = S_POPW;
              end
            end
            ACT_LENGTH: begin
              out_word_nxt.tally = TALLY_W'(occ_r);
            end
            ACT_SEARCH: begin
              // Arm the compare unit and start the walk at the front.
              mctrl.load     = 1'b1;
              scan_ptr_nxt   = front_r;
              rem_nxt        = occ_r;
              out_strobe_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            default: begin
              // undefined action: zero result, no state change
            end
          endcase
        end
      end

      S_POPW: begin
        out_word_nxt.popped_value = $signed(rd_data);
        out_strobe_nxt            = 1'b1;
        state_nxt                 = S_IDLE;
      end

      S_SCAN: begin
        // Compare the word read last cycle, issue the next read.
        mctrl.en = pend_r;
        if (rem_r != '0) begin
          rd_en        = 1'b1;
          rd_addr      = scan_ptr_r;
          scan_ptr_nxt = slot_inc(scan_ptr_r);
          rem_nxt      = rem_r - OCC_W'(1);
          pend_nxt     = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        out_word_nxt   = '0;
        out_word_nxt.tally = TALLY_W'(match_cnt);
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      occ_r        <= '0;
      scan_ptr_r   <= '0;
      rem_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      occ_r        <= occ_nxt;
      scan_ptr_r   <= scan_ptr_nxt;
      rem_r        <= rem_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Entry storage: one write and one registered read per cycle.
  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_word.data_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit for the search walk.
  bdq_match #(
    .CNT_W (OCC_W)
  ) u_match (
    .clk     (clk),
    .ctrl    (mctrl),
    .key     (in_word.data_value),
    .rd_data (rd_data),
    .count   (match_cnt)
  );

`include "assert_macros.svh"

  `BDQ_ASSERT(a_occ_bound, clk, rst_n, occ_r <= OCC_W'(CAPACITY))
  `BDQ_ASSERT(a_front_bound, clk, rst_n, front_r <= IDX_W'(CAPACITY - 1))
  `BDQ_ASSERT(a_pend_in_scan, clk, rst_n, pend_r |-> (state_r == S_SCAN))
  `BDQ_ASSERT(a_short_result, clk, rst_n, (accept && (in_word.action == ACT_PUSH_BACK || in_word.action == ACT_PUSH_FRONT || in_word.action == ACT_LENGTH)) |=> (out_strobe && !busy))

endmodule

`default_nettype wire

FILE: verif/bdq_checker.sv
module bdq_checker #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  bdq_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  bdq_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // shadow copy of the deque
  logic signed [DATA_W-1:0] slots [DEPTH];
  int                       head;
  int                       count;
  out_word_t                owed_results [$];

  // applies one action to the shadow deque, returns the result word it gives
  function automatic out_word_t apply_action(in_word_t w);
    out_word_t r;
    int        hits;
    r    = '0;
    hits = 0;
    case (w.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (w.action == ACT_PUSH_BACK) begin
            slots[(head + count) % DEPTH] = w.data_value;
          end else begin
            head        = (head + DEPTH - 1) % DEPTH;
            slots[head] = w.data_value;
          end
          count++;
        end
      end
      ACT_POP_BACK: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          count--;
          r.popped_value = slots[(head + count) % DEPTH];
        end
      end
      ACT_POP_FRONT: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = slots[head];
          head           = (head + 1) % DEPTH;
          count--;
        end
      end
      ACT_LENGTH: r.tally = TALLY_W'(count);
      ACT_SEARCH: begin
        for (int i = 0; i < count; i++) begin
          if (slots[(head + i) % DEPTH] == w.data_value) hits++;
        end
        r.tally = TALLY_W'(hits);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      head       = 0;
      count      = 0;
      fail_count = 0;
      owed_results.delete();
    end else begin
      if (out_strobe) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, out_word.status);
          check_field("popped_value", want.popped_value, out_word.popped_value);
          check_field("tally", want.tally, out_word.tally);
        end
      end
      if (start && !busy) owed_results.push_back(apply_action(in_word));
    end
    pending = owed_results.size();
  end

endmodule

FILE: verif/tb_bounded_deque_with_match_count_core.sv
module tb_bounded_deque_with_match_count_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // action codes the block leaves undefined; they must give an all-zero result
  localparam logic [ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

  // mix of actions in the random part
  localparam int TILT_FILL  = 0;  // mostly pushes, drives the deque to full
  localparam int TILT_DRAIN = 1;  // mostly pops, drives it to empty
  localparam int TILT_MIXED = 2;

  localparam int RUN_ITEMS = 1500;
  // worst case: every word a search over a full deque, plus idle gaps
  localparam int LIMIT     = 600000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  int fail_count;
  int pending;
  int cycles;
  int idle_pct;

  bounded_deque_with_match_count_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // predicts every result word and compares; hands back the failure count
  bdq_checker #(.DEPTH(64)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Data values: the signed extremes, zero and -1, tiny values, random words,
  // and a value favored per stretch so that searches find many matches.
  function automatic logic signed [DATA_W-1:0] pick_value(logic signed [DATA_W-1:0] favored);
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return favored;
      6:       return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(int tilt);
    int roll;
    int push_lim;
    int pop_lim;
    roll = $urandom_range(99);
    case (tilt)
      TILT_FILL:  begin push_lim = 80; pop_lim = 90; end
      TILT_DRAIN: begin push_lim = 15; pop_lim = 82; end
      default:    begin push_lim = 40; pop_lim = 80; end
    endcase
    if (roll < push_lim) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (roll < pop_lim)  return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (roll < pop_lim + 7) return ACT_LENGTH;
    if (roll < 98)       return ACT_SEARCH;
    return $urandom_range(1) ? ACT_RSVD_6 : ACT_RSVD_7;
  endfunction

  // Offers one word and returns once it is taken. Idle cycles come first,
  // at idle_pct percent per cycle, with noise on the payload while start is
  // low. Each falling edge carries a single update of start.
  task automatic send_word(logic [ACTION_W-1:0] act, logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= '{action: ACTION_W'($urandom), data_value: $urandom};
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= '{action: act, data_value: val};
    // taken at the first rising edge that sees busy low
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int                       tilt;
    int                       tilt_left;
    logic signed [DATA_W-1:0] favored;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    idle_pct  = 0;
    tilt      = TILT_MIXED;
    tilt_left = 0;
    favored   = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: pops and queries on an empty deque, undefined actions,
    // the signed extremes at both ends, then unwind from both ends.
    send_word(ACT_POP_BACK, 32'sd0);
    send_word(ACT_POP_FRONT, 32'sd0);
    send_word(ACT_LENGTH, 32'sd0);
    send_word(ACT_SEARCH, 32'sd0);
    send_word(ACT_RSVD_6, -32'sd1);
    send_word(ACT_RSVD_7, 32'sh8000_0000);
    send_word(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_word(ACT_PUSH_FRONT, 32'sh8000_0000);   // front index wraps below zero
    send_word(ACT_PUSH_BACK, -32'sd1);
    send_word(ACT_PUSH_FRONT, 32'sd0);
    send_word(ACT_LENGTH, -32'sd1);
    send_word(ACT_SEARCH, 32'sh7fff_ffff);
    send_word(ACT_SEARCH, -32'sd1);
    send_word(ACT_SEARCH, 32'sd5);               // no match
    send_word(ACT_POP_FRONT, 32'sd0);
    send_word(ACT_POP_BACK, 32'sd0);
    send_word(ACT_POP_FRONT, 32'sd0);
    send_word(ACT_POP_BACK, 32'sd0);
    send_word(ACT_POP_BACK, 32'sd0);             // empty again
    send_word(ACT_PUSH_FRONT, 32'sd1);
    send_word(ACT_POP_BACK, 32'sd0);             // pushed at front, leaves at back
    send_word(ACT_LENGTH, 32'sd0);

    // Random: stretches of fill, drain or mixed traffic so the deque keeps
    // crossing between empty and full. Three thirds with different idling.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 20 : (phase == 1) ? 56 : 0;
      repeat (RUN_ITEMS / 3) begin
        if (tilt_left == 0) begin
          tilt      = $urandom_range(TILT_MIXED);
          tilt_left = $urandom_range(160, 60);
          favored   = $urandom;
        end
        tilt_left--;
        send_word(pick_action(tilt), pick_value(favored));
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then keep idling to catch strays
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
